// ===== hdl/escaped_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame deframer
// Concurrent assertion wrappers that compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_DEFRAMER_MACROS_SVH
`define ESCAPED_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define EFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define EFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define EFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer package
// Shared types, framing constants and the payload length table.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam logic [7:0] MARK_BYTE    = 8'h1A;
  localparam logic [7:0] TYPE_SHORT   = 8'h31;
  localparam logic [7:0] TYPE_LONG    = 8'h33;
  localparam int         STAMP_BYTES  = 6;
  localparam int         MAX_PAYLOAD  = 14;
  localparam logic [4:0] LEVEL_POS    = 5'd6;
  localparam logic [4:0] PAYLOAD_BASE = 5'd7;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_TYPE,
    ST_BODY,
    ST_ESC,
    ST_EMIT
  } efd_state_t;

  typedef struct packed {
    logic       start_frame;
    logic       take_body;
    logic       emit_step;
    logic [1:0] bump;
  } efd_cmd_t;

  typedef struct packed {
    logic is_mark;
    logic is_type;
    logic body_end;
    logic emit_last;
  } efd_stat_t;

  function automatic logic [4:0] payload_len(input logic [1:0] kind);
    logic [4:0] len;
    case (kind)
      2'd0:    len = 5'd2;
      2'd1:    len = 5'd7;
      default: len = 5'd14;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/efd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer controller
// Tracks the framing phase and sequences the result items of a finished frame.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_macros.svh"

module efd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  efd_pkg::efd_stat_t stat,
  output efd_pkg::efd_cmd_t  cmd
);
  import efd_pkg::*;

  efd_state_t state_r, state_nxt;
  logic       take;
  logic       give;

  assign in_ready  = (state_r != ST_EMIT);
  assign out_valid = (state_r == ST_EMIT);
  assign take      = in_valid && in_ready;
  assign give      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (take && stat.is_mark) begin
          state_nxt = ST_TYPE;
        end
      end
      ST_TYPE: begin
        if (take) begin
          if (stat.is_type) begin
            state_nxt = ST_BODY;
          end else if (!stat.is_mark) begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_BODY: begin
        if (take) begin
          if (stat.is_mark) begin
            state_nxt = ST_ESC;
          end else if (stat.body_end) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ESC: begin
        if (take) begin
          if (stat.is_mark) begin
            state_nxt = stat.body_end ? ST_EMIT : ST_BODY;
          end else if (stat.is_type) begin
            state_nxt = ST_BODY;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_EMIT: begin
        if (give && stat.emit_last) begin
          state_nxt = ST_HUNT;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_HUNT: begin
        if (take && !stat.is_mark) begin
          cmd.bump = 2'd1;
        end
      end
      ST_TYPE: begin
        if (take) begin
          if (stat.is_type) begin
            cmd.start_frame = 1'b1;
          end else if (stat.is_mark) begin
            cmd.bump = 2'd1;
          end else begin
            cmd.bump = 2'd2;
          end
        end
      end
      ST_BODY: begin
        if (take && !stat.is_mark) begin
          cmd.take_body = 1'b1;
        end
      end
      ST_ESC: begin
        if (take) begin
          if (stat.is_mark) begin
            cmd.take_body = 1'b1;
          end else if (stat.is_type) begin
            cmd.start_frame = 1'b1;
            cmd.bump        = 2'd1;
          end else begin
            // The broken escape, the abandoned marker and the stray byte each count.
            cmd.bump = 2'd3;
          end
        end
      end
      ST_EMIT: begin
        cmd.emit_step = give;
      end
      default: cmd = '0;
    endcase
  end

  `EFD_ASSERT_NEXT(a_emit_done, clk, rst_n, give && stat.emit_last, in_ready && !out_valid, "frame end did not return to hunting")
  `EFD_ASSERT_NEXT(a_frame_out, clk, rst_n, cmd.take_body && stat.body_end, out_valid, "finished frame produced no item")

endmodule

// ===== hdl/efd_dp.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer datapath
// Holds timestamp, level, payload bytes, counters and the malformed count.
// ----------------------------------------------------------------------------
`include "escaped_frame_deframer_macros.svh"

module efd_dp #(
  parameter int BAD_COUNT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  efd_pkg::efd_cmd_t  cmd,
  output efd_pkg::efd_stat_t stat,
  output logic [1:0]         out_frame_kind,
  output logic [47:0]        out_stamp,
  output logic [7:0]         out_level,
  output logic [7:0]         out_data_byte,
  output logic [3:0]         out_byte_index,
  output logic               out_last_byte,
  output logic [31:0]        out_bad_bytes
);
  import efd_pkg::*;

  logic [1:0]                kind_r;
  logic [4:0]                body_cnt_r;
  logic [47:0]               stamp_r;
  logic [7:0]                level_r;
  logic [7:0]                store_r [MAX_PAYLOAD];
  logic [3:0]                idx_r;
  logic [BAD_COUNT_BITS-1:0] bad_cnt_r;
  logic [BAD_COUNT_BITS-1:0] bad_cnt_nxt;
  logic [BAD_COUNT_BITS:0]   bad_sum;
  logic [4:0]                len;
  logic [3:0]                wr_idx;

  assign len    = payload_len(kind_r);
  assign wr_idx = 4'(body_cnt_r - PAYLOAD_BASE);

  always_comb begin
    stat.is_mark   = (in_byte == MARK_BYTE);
    stat.is_type   = in_byte inside {[TYPE_SHORT:TYPE_LONG]};
    stat.body_end  = ((body_cnt_r + 5'd1) == (PAYLOAD_BASE + len));
    stat.emit_last = (({1'b0, idx_r} + 5'd1) == len);
  end

  always_comb begin
    bad_sum = {1'b0, bad_cnt_r} + (BAD_COUNT_BITS + 1)'(cmd.bump);
    if (bad_sum[BAD_COUNT_BITS]) begin
      bad_cnt_nxt = '1;
    end else begin
      bad_cnt_nxt = bad_sum[BAD_COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= '0;
      body_cnt_r <= '0;
      idx_r      <= '0;
      bad_cnt_r  <= '0;
    end else begin
      bad_cnt_r <= bad_cnt_nxt;
      if (cmd.start_frame) begin
        kind_r     <= 2'(in_byte - TYPE_SHORT);
        body_cnt_r <= '0;
      end else if (cmd.take_body) begin
        body_cnt_r <= body_cnt_r + 5'd1;
      end
      if (cmd.emit_step) begin
        idx_r <= stat.emit_last ? 4'd0 : idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_body) begin
      if (body_cnt_r < 5'(STAMP_BYTES)) begin
        stamp_r <= {stamp_r[39:0], in_byte};
      end else if (body_cnt_r == LEVEL_POS) begin
        level_r <= in_byte;
      end else begin
        store_r[wr_idx] <= in_byte;
      end
    end
  end

  assign out_frame_kind = kind_r;
  assign out_stamp      = stamp_r;
  assign out_level      = level_r;
  assign out_data_byte  = store_r[idx_r];
  assign out_byte_index = idx_r;
  assign out_last_byte  = stat.emit_last;

  generate
    if (BAD_COUNT_BITS >= 32) begin : g_bad_wide
      assign out_bad_bytes = bad_cnt_r[31:0];
    end else begin : g_bad_narrow
      assign out_bad_bytes = {{(32 - BAD_COUNT_BITS){1'b0}}, bad_cnt_r};
    end
  endgenerate

  `EFD_ASSERT_SAME(a_idx_range, clk, rst_n, cmd.emit_step, {1'b0, idx_r} < len, "payload index past frame length")
  `EFD_ASSERT_SAME(a_body_range, clk, rst_n, cmd.take_body, body_cnt_r < (PAYLOAD_BASE + len), "body byte past frame end")

endmodule

// ===== hdl/escaped_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Escaped frame deframer
// Takes one raw byte per item, strips byte stuffing and delivers each payload
// byte of a finished frame with its timestamp, level and malformed count.
// ----------------------------------------------------------------------------
// While a frame is being parsed the block takes one byte per cycle. When the
// final body byte arrives it presents the payload one byte per cycle while
// out_ready is high (2, 7 or 14 items, set by the frame type) from its payload
// register file and holds in_ready low until the last item is taken.
// ----------------------------------------------------------------------------
module escaped_frame_deframer #(
  parameter int BAD_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [47:0] out_stamp,
  output logic [7:0]  out_level,
  output logic [7:0]  out_data_byte,
  output logic [3:0]  out_byte_index,
  output logic        out_last_byte,
  output logic [31:0] out_bad_bytes
);
  import efd_pkg::*;

  efd_cmd_t  cmd;
  efd_stat_t stat;

  efd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  efd_dp #(
    .BAD_COUNT_BITS (BAD_COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_byte),
    .cmd            (cmd),
    .stat           (stat),
    .out_frame_kind (out_frame_kind),
    .out_stamp      (out_stamp),
    .out_level      (out_level),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_last_byte  (out_last_byte),
    .out_bad_bytes  (out_bad_bytes)
  );

endmodule
